// File: design/fqk_pkg.sv
// ----------------------------------------------------------------------------
// fqk_pkg
// Shared types and codes for the frequency top-k heap unit.
// ----------------------------------------------------------------------------
package fqk_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 2;
    localparam int K_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EMIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_TOP,
        S_POP_LAST,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_EMPTY
    } state_t;

endpackage

// File: design/fqk_in_if.sv
// ----------------------------------------------------------------------------
// fqk_in_if
// Request channel: operation, value and pop count.
// ----------------------------------------------------------------------------
interface fqk_in_if;
    logic                                valid;
    logic                                ready;
    logic [fqk_pkg::OP_W-1:0]            op;
    logic signed [fqk_pkg::VALUE_W-1:0]  value;
    logic [fqk_pkg::K_W-1:0]             k_count;

    modport source (output valid, op, value, k_count, input ready);
    modport sink   (input valid, op, value, k_count, output ready);
endinterface

// File: design/fqk_out_if.sv
// ----------------------------------------------------------------------------
// fqk_out_if
// Result channel: one popped entry per transfer.
// ----------------------------------------------------------------------------
interface fqk_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fqk_pkg::VALUE_W-1:0]  top_value;
    logic [fqk_pkg::COUNT_W-1:0]         top_count;
    logic                                valid_res;
    logic                                overflowed;
    logic                                last;

    modport source (output valid, top_value, top_count, valid_res, overflowed, last,
                    input ready);
    modport sink   (input valid, top_value, top_count, valid_res, overflowed, last,
                    output ready);
endinterface

// File: design/fqk_ram.sv
// ----------------------------------------------------------------------------
// fqk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/frequency_top_k_heap_unit.sv
// ----------------------------------------------------------------------------
// frequency_top_k_heap_unit
// Counts 32-bit values in a max-heap keyed by count and pops the top k.
// ----------------------------------------------------------------------------
// One request is handled at a time, all through a single heap RAM with one
// read and one write port. After an insert is taken, the live entries are
// scanned one per cycle until a match or the last entry; a miss on a full heap
// sets the overflow flag and drops the value, else the entry sifts up,
// reading and comparing its parent at each level. An emit pops one entry per
// result: it reads the root and the last entry, then per level of sift-down
// the left child and any right child, and writes the entry where it settles.
// A clear or an unused op code is done as it is taken. A result sits in an
// output register; the next pop waits until it has been taken.
module frequency_top_k_heap_unit #(
    parameter int CAPACITY = 256,
    parameter int MAX_K    = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    fqk_in_if.sink    inp,
    fqk_out_if.source outp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int NW = (SW > fqk_pkg::K_W) ? SW : fqk_pkg::K_W;
    localparam int EW = fqk_pkg::VALUE_W + fqk_pkg::COUNT_W;

    fqk_pkg::state_t state_reg, state_next;

    logic [SW-1:0]               size_reg, size_next;
    logic                        ovf_reg, ovf_next;
    logic [IW-1:0]               pos_reg, pos_next;
    fqk_pkg::entry_t             cur_reg, cur_next;
    fqk_pkg::entry_t             lch_reg, lch_next;
    logic [fqk_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [SW-1:0]               scan_reg, scan_next;
    logic                        chk_reg, chk_next;
    logic [IW-1:0]               chk_addr_reg, chk_addr_next;
    logic [fqk_pkg::K_W-1:0]     rem_reg, rem_next;

    logic                        ov_reg, ov_next;
    fqk_pkg::entry_t             ot_reg, ot_next;
    logic                        ores_reg, ores_next;
    logic                        oovf_reg, oovf_next;
    logic                        olast_reg, olast_next;

    logic                        wr_en, rd_en;
    logic [IW-1:0]               wr_addr, rd_addr;
    fqk_pkg::entry_t             wr_data, rd_data;
    logic [EW-1:0]               rd_raw;

    logic                        accept, out_free;
    logic [fqk_pkg::K_W-1:0]     k_sat;
    logic [NW-1:0]               n_pop;
    logic [IW:0]                 lidx, ridx;
    logic [IW-1:0]               parent;
    logic                        match, scan_more, up_swap, take_left, dn_swap;
    logic                        has_right;
    fqk_pkg::entry_t             child;
    logic [IW-1:0]               child_idx;

    fqk_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data  = rd_raw;
    assign inp.ready = (state_reg == fqk_pkg::S_IDLE);
    assign accept   = inp.valid && inp.ready;
    assign out_free = !ov_reg || outp.ready;

    assign k_sat = (inp.k_count > fqk_pkg::K_W'(MAX_K)) ? fqk_pkg::K_W'(MAX_K)
                                                        : inp.k_count;
    assign n_pop = (NW'(k_sat) < NW'(size_reg)) ? NW'(k_sat) : NW'(size_reg);

    assign lidx      = {pos_reg, 1'b1};
    assign ridx      = lidx + (IW+1)'(1);
    assign has_right = ((IW+1)'(ridx) < (IW+1)'(size_reg));
    assign parent    = (pos_reg - IW'(1)) >> 1;
    assign match     = chk_reg && (rd_data.value == key_reg);
    assign scan_more = (scan_reg < size_reg);
    assign up_swap   = (rd_data.count < cur_reg.count);

    // Right child unless the left is strictly greater; left alone in DN_L.
    assign take_left = (state_reg == fqk_pkg::S_DN_L) || (lch_reg.count > rd_data.count);
    assign child     = (state_reg == fqk_pkg::S_DN_L) ? rd_data
                     : (take_left ? lch_reg : rd_data);
    assign child_idx = take_left ? lidx[IW-1:0] : ridx[IW-1:0];
    assign dn_swap   = (cur_reg.count < child.count);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqk_pkg::S_IDLE:
            begin
                if (accept && inp.op == fqk_pkg::OP_INSERT)
                begin
                    state_next = fqk_pkg::S_SCAN;
                end
                else if (accept && inp.op == fqk_pkg::OP_EMIT)
                begin
                    state_next = (n_pop == '0) ? fqk_pkg::S_EMPTY : fqk_pkg::S_POP_RD;
                end
            end
            fqk_pkg::S_SCAN:
            begin
                if (match)
                begin
                    state_next = fqk_pkg::S_UP_RD;
                end
                else if (!scan_more)
                begin
                    state_next = (size_reg == SW'(CAPACITY)) ? fqk_pkg::S_IDLE
                                                             : fqk_pkg::S_UP_RD;
                end
            end
            fqk_pkg::S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = fqk_pkg::S_IDLE;
                end
                else
                begin
                    state_next = fqk_pkg::S_UP_CMP;
                end
            end
            fqk_pkg::S_UP_CMP:
            begin
                state_next = up_swap ? fqk_pkg::S_UP_RD : fqk_pkg::S_IDLE;
            end
            fqk_pkg::S_POP_RD:
            begin
                if (out_free)
                begin
                    state_next = fqk_pkg::S_POP_TOP;
                end
            end
            fqk_pkg::S_POP_TOP:
            begin
                state_next = fqk_pkg::S_POP_LAST;
            end
            fqk_pkg::S_POP_LAST:
            begin
                if (size_reg == SW'(1))
                begin
                    state_next = (rem_reg == fqk_pkg::K_W'(1)) ? fqk_pkg::S_IDLE
                                                               : fqk_pkg::S_POP_RD;
                end
                else
                begin
                    state_next = fqk_pkg::S_DN_RD;
                end
            end
            fqk_pkg::S_DN_RD:
            begin
                if (lidx >= (IW+1)'(size_reg))
                begin
                    state_next = (rem_reg == '0) ? fqk_pkg::S_IDLE : fqk_pkg::S_POP_RD;
                end
                else
                begin
                    state_next = fqk_pkg::S_DN_L;
                end
            end
            fqk_pkg::S_DN_L, fqk_pkg::S_DN_R:
            begin
                if (state_reg == fqk_pkg::S_DN_L && has_right)
                begin
                    state_next = fqk_pkg::S_DN_R;
                end
                else if (dn_swap)
                begin
                    state_next = fqk_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = (rem_reg == '0) ? fqk_pkg::S_IDLE : fqk_pkg::S_POP_RD;
                end
            end
            fqk_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = fqk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqk_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        size_next     = size_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        lch_next      = lch_reg;
        key_next      = key_reg;
        scan_next     = scan_reg;
        chk_next      = 1'b0;
        chk_addr_next = chk_addr_reg;
        rem_next      = rem_reg;
        ov_next       = ov_reg && !outp.ready;
        ot_next       = ot_reg;
        ores_next     = ores_reg;
        oovf_next     = oovf_reg;
        olast_next    = olast_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = cur_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        case (state_reg)
            fqk_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (inp.op)
                        fqk_pkg::OP_INSERT:
                        begin
                            key_next  = inp.value;
                            scan_next = '0;
                        end
                        fqk_pkg::OP_EMIT:
                        begin
                            rem_next = fqk_pkg::K_W'(n_pop);
                        end
                        fqk_pkg::OP_CLEAR:
                        begin
                            size_next = '0;
                            ovf_next  = 1'b0;
                        end
                        default:
                        begin
                            size_next = size_reg;
                        end
                    endcase
                end
            end
            fqk_pkg::S_SCAN:
            begin
                if (match)
                begin
                    cur_next.value = rd_data.value;
                    cur_next.count = (rd_data.count == fqk_pkg::COUNT_MAX)
                                   ? rd_data.count : rd_data.count + 16'd1;
                    pos_next = chk_addr_reg;
                end
                else if (scan_more)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[IW-1:0];
                    chk_next      = 1'b1;
                    chk_addr_next = scan_reg[IW-1:0];
                    scan_next     = scan_reg + SW'(1);
                end
                else if (size_reg == SW'(CAPACITY))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    // append as a new leaf with a count of one
                    cur_next.value = key_reg;
                    cur_next.count = 16'd1;
                    pos_next       = size_reg[IW-1:0];
                    size_next      = size_reg + SW'(1);
                end
            end
            fqk_pkg::S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            fqk_pkg::S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (up_swap)
                begin
                    wr_data  = rd_data;
                    pos_next = parent;
                end
            end
            fqk_pkg::S_POP_RD:
            begin
                if (out_free)
                begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            fqk_pkg::S_POP_TOP:
            begin
                ov_next    = 1'b1;
                ot_next    = rd_data;
                ores_next  = 1'b1;
                oovf_next  = ovf_reg;
                olast_next = (rem_reg == fqk_pkg::K_W'(1));
                rd_en      = 1'b1;
                rd_addr    = IW'(size_reg - SW'(1));
            end
            fqk_pkg::S_POP_LAST:
            begin
                cur_next  = rd_data;
                size_next = size_reg - SW'(1);
                rem_next  = rem_reg - fqk_pkg::K_W'(1);
                pos_next  = '0;
            end
            fqk_pkg::S_DN_RD:
            begin
                if (lidx >= (IW+1)'(size_reg))
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = lidx[IW-1:0];
                end
            end
            fqk_pkg::S_DN_L, fqk_pkg::S_DN_R:
            begin
                if (state_reg == fqk_pkg::S_DN_L && has_right)
                begin
                    lch_next = rd_data;
                    rd_en    = 1'b1;
                    rd_addr  = ridx[IW-1:0];
                end
                else
                begin
                    wr_en = 1'b1;
                    if (dn_swap)
                    begin
                        wr_data  = child;
                        pos_next = child_idx;
                    end
                end
            end
            fqk_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ot_next    = '0;
                    ores_next  = 1'b0;
                    oovf_next  = ovf_reg;
                    olast_next = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqk_pkg::S_IDLE;
            size_reg  <= '0;
            ovf_reg   <= 1'b0;
            chk_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            ovf_reg   <= ovf_next;
            chk_reg   <= chk_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        lch_reg      <= lch_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        rem_reg      <= rem_next;
        ot_reg       <= ot_next;
        ores_reg     <= ores_next;
        oovf_reg     <= oovf_next;
        olast_reg    <= olast_next;
    end

    assign outp.valid      = ov_reg;
    assign outp.top_value  = ot_reg.value;
    assign outp.top_count  = ot_reg.count;
    assign outp.valid_res  = ores_reg;
    assign outp.overflowed = oovf_reg;
    assign outp.last       = olast_reg;

endmodule

// File: design/fqk_checker.sv
// ----------------------------------------------------------------------------
// fqk_checker
// Port-level checks for the frequency top-k heap unit.
// ----------------------------------------------------------------------------
module fqk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] top_count,
    input logic        valid_res,
    input logic        last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> last && top_count == 16'd0)
        else $error("empty result malformed");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> top_count != 16'd0)
        else $error("popped entry with zero count");

    // no new request while an emit run is unfinished
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("request taken during emit run");

endmodule

bind frequency_top_k_heap_unit fqk_checker u_fqk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (inp.ready),
    .out_valid (outp.valid),
    .out_ready (outp.ready),
    .top_count (outp.top_count),
    .valid_res (outp.valid_res),
    .last      (outp.last)
);
